[hw/rtl/fun_pkg.sv]
// Shared constants for the face unit normal pipeline.
`timescale 1ns / 1ps
`default_nettype none
package fun_pkg;
    // default coordinate and normal formats
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    // normalized magnitude width: top bit lands on bit 30
    localparam int NORM_W   = 31;
    // sum of three squared normalized magnitudes and its root
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int SQRT_STEPS = 32;
endpackage
`default_nettype wire

[hw/rtl/face_unit_normal.sv]
// Top level: unit normal of one face from its three vertices.
// Usage:
//   Input words on s_t* carry vertices A, B and C (nine signed coordinates).
//   Each word gives one result word on m_t*: n_x, n_y, n_z in signed fixed
//   point with NORMAL_FRAC_BITS fraction bits, and the degenerate flag in
//   m_tuser. The normal is (C-A) x (B-A) scaled to unit length.
//   Throughput: one word per cycle while the pipeline is not held. The
//   pipeline holds 32 square-root digit cells and NORMAL_FRAC_BITS+2
//   divider cells.
//   The output register is backed by a skid register: input is still taken
//   while a result waits. Once the skid register is full the whole
//   pipeline holds and s_tready drops until the receiver takes a word.
//   Reset (aresetn low, synchronous) clears all valid bits; the pipeline
//   comes up empty and ready. A face with a zero cross product gives a zero
//   vector with degenerate set.
`timescale 1ns / 1ps
`default_nettype none
module face_unit_normal #(
    parameter int COORD_BITS       = fun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = fun_pkg::FRAC_BITS_DEF,
    parameter int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((3 * (NORMAL_FRAC_BITS + 2) + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  wire  [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  wire              m_tready,
    // n_x, n_y, n_z from bit 0 up
    output logic [OUT_W-1:0] m_tdata,
    // degenerate
    output logic             m_tuser
);
    localparam int C     = COORD_BITS;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int D     = C + 1;
    localparam int MW    = 2 * D;
    localparam int LZ_W  = $clog2(MW);
    localparam int NRM   = fun_pkg::NORM_W;
    localparam int SQW   = 2 * NRM;
    localparam int SW    = fun_pkg::SUM_W;
    localparam int RW    = fun_pkg::ROOT_W;
    localparam int NST   = fun_pkg::SQRT_STEPS;
    localparam int PAY_W = 3 * NRM + 4;
    localparam int QW    = F + 2;
    localparam int NW    = NRM + F + 2;
    localparam int DW    = 3 * QW;

    logic en;

    // stage 1: edge vectors
    logic                v1_reg;
    logic signed [D-1:0] u_reg [3];
    logic signed [D-1:0] w_reg [3];
    logic signed [D-1:0] u_next [3];
    logic signed [D-1:0] w_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u_next[k] = D'($signed(s_tdata[(6 + k) * C +: C]))
                      - D'($signed(s_tdata[k * C +: C]));
            w_next[k] = D'($signed(s_tdata[(3 + k) * C +: C]))
                      - D'($signed(s_tdata[k * C +: C]));
        end
    end

    // stage 2: six products
    logic                  v2_reg;
    logic signed [MW-1:0]  p_reg [6];

    // stage 3: cross components as magnitude and sign
    logic                  v3_reg;
    logic [MW-1:0]         mag3_reg [3];
    logic [MW-1:0]         mag3_next [3];
    logic [2:0]            sg3_reg, sg3_next;
    logic signed [MW:0]    cr [3];

    always_comb begin
        cr[0] = (MW + 1)'(p_reg[0]) - (MW + 1)'(p_reg[1]);
        cr[1] = (MW + 1)'(p_reg[2]) - (MW + 1)'(p_reg[3]);
        cr[2] = (MW + 1)'(p_reg[4]) - (MW + 1)'(p_reg[5]);
        for (int k = 0; k < 3; k++) begin
            sg3_next[k]  = cr[k][MW];
            mag3_next[k] = cr[k][MW] ? MW'(-cr[k]) : MW'(cr[k]);
        end
    end

    // stage 4: leading zero count of the largest magnitude
    logic              v4_reg;
    logic [MW-1:0]     mag4_reg [3];
    logic [2:0]        sg4_reg;
    logic              dg4_reg;
    logic [LZ_W-1:0]   lz4_reg, lz_next;
    logic [MW-1:0]     mor;

    always_comb begin
        mor     = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
        lz_next = '0;
        for (int i = 0; i < MW; i++) begin
            if (mor[i]) begin
                lz_next = LZ_W'(MW - 1 - i);
            end
        end
    end

    // stage 5: normalize so the largest has its top bit at bit NRM-1
    logic              v5_reg;
    logic [NRM-1:0]    n5_reg [3];
    logic [NRM-1:0]    n5_next [3];
    logic [2:0]        sg5_reg;
    logic              dg5_reg;
    logic [MW+NRM-1:0] ext [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ext[k]     = {mag4_reg[k], NRM'(0)} << lz4_reg;
            n5_next[k] = ext[k][MW+NRM-1 -: NRM];
        end
    end

    // stage 6: squares; stage 7: sum
    logic              v6_reg, v7_reg;
    logic [SQW-1:0]    sq6_reg [3];
    logic [NRM-1:0]    n6_reg [3];
    logic [NRM-1:0]    n7_reg [3];
    logic [2:0]        sg6_reg, sg7_reg;
    logic              dg6_reg, dg7_reg;
    logic [SW-1:0]     sum7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // advance front stages
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u_next;
            w_reg    <= w_next;
            p_reg[0] <= MW'(u_reg[1] * w_reg[2]);
            p_reg[1] <= MW'(u_reg[2] * w_reg[1]);
            p_reg[2] <= MW'(u_reg[2] * w_reg[0]);
            p_reg[3] <= MW'(u_reg[0] * w_reg[2]);
            p_reg[4] <= MW'(u_reg[0] * w_reg[1]);
            p_reg[5] <= MW'(u_reg[1] * w_reg[0]);
            mag3_reg <= mag3_next;
            sg3_reg  <= sg3_next;
            mag4_reg <= mag3_reg;
            sg4_reg  <= sg3_reg;
            dg4_reg  <= (mor == '0);
            lz4_reg  <= lz_next;
            n5_reg   <= n5_next;
            sg5_reg  <= sg4_reg;
            dg5_reg  <= dg4_reg;
            for (int k = 0; k < 3; k++) begin
                sq6_reg[k] <= SQW'(n5_reg[k]) * SQW'(n5_reg[k]);
            end
            n6_reg   <= n5_reg;
            sg6_reg  <= sg5_reg;
            dg6_reg  <= dg5_reg;
            sum7_reg <= SW'(sq6_reg[0]) + SW'(sq6_reg[1]) + SW'(sq6_reg[2]);
            n7_reg   <= n6_reg;
            sg7_reg  <= sg6_reg;
            dg7_reg  <= dg6_reg;
        end
    end

    // square root: one cell per root digit
    logic             sq_v   [NST+1];
    logic [SW-1:0]    sq_rem [NST+1];
    logic [SW-1:0]    sq_res [NST+1];
    logic [PAY_W-1:0] sq_pay [NST+1];

    assign sq_v[0]   = v7_reg;
    assign sq_rem[0] = sum7_reg;
    assign sq_res[0] = '0;
    assign sq_pay[0] = {dg7_reg, sg7_reg, n7_reg[2], n7_reg[1], n7_reg[0]};

    for (genvar g = 0; g < NST; g++) begin : g_sqrt
        fun_sqrt_cell #(
            .PAY_W   (PAY_W),
            .BIT_POS (SW - 2 - 2 * g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_rem    (sq_rem[g]),
            .in_res    (sq_res[g]),
            .in_pay    (sq_pay[g]),
            .out_valid (sq_v[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_res   (sq_res[g+1]),
            .out_pay   (sq_pay[g+1])
        );
    end

    // divider setup: numerator with half the root added for rounding
    logic          vd_reg;
    logic [NW-1:0] num_reg [3];
    logic [RW-1:0] root;
    logic [RW-1:0] rt_reg;
    logic [2:0]    sgd_reg;
    logic          dgd_reg;

    assign root = RW'(sq_res[NST]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= sq_v[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= (NW'(sq_pay[NST][k * NRM +: NRM]) << F) + NW'(root >> 1);
            end
            rt_reg  <= root;
            sgd_reg <= sq_pay[NST][3 * NRM +: 3];
            dgd_reg <= sq_pay[NST][PAY_W-1];
        end
    end

    // divider: one cell per quotient bit, high bit first
    logic          dv_v    [QW+1];
    logic [NW-1:0] dv_rem  [QW+1][3];
    logic [QW-1:0] dv_q    [QW+1][3];
    logic [RW-1:0] dv_r    [QW+1];
    logic [2:0]    dv_sign [QW+1];
    logic          dv_deg  [QW+1];

    assign dv_v[0]    = vd_reg;
    assign dv_rem[0]  = num_reg;
    assign dv_q[0]    = '{default: '0};
    assign dv_r[0]    = rt_reg;
    assign dv_sign[0] = sgd_reg;
    assign dv_deg[0]  = dgd_reg;

    for (genvar g = 0; g < QW; g++) begin : g_div
        fun_div_cell #(
            .FRAC_BITS (F),
            .BIT_POS   (QW - 1 - g),
            .NW        (NW),
            .QW        (QW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[g]),
            .in_rem    (dv_rem[g]),
            .in_q      (dv_q[g]),
            .in_r      (dv_r[g]),
            .in_sign   (dv_sign[g]),
            .in_deg    (dv_deg[g]),
            .out_valid (dv_v[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_q     (dv_q[g+1]),
            .out_r     (dv_r[g+1]),
            .out_sign  (dv_sign[g+1]),
            .out_deg   (dv_deg[g+1])
        );
    end

    // saturate at one, apply sign, zero a degenerate face
    localparam logic [QW-1:0] ONE = QW'(1) << F;
    logic [DW-1:0] res_data;
    logic [QW-1:0] sat [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sat[k] = (dv_q[QW][k] > ONE) ? ONE : dv_q[QW][k];
            if (dv_deg[QW]) begin
                res_data[k * QW +: QW] = '0;
            end else if (dv_sign[QW][k]) begin
                res_data[k * QW +: QW] = -sat[k];
            end else begin
                res_data[k * QW +: QW] = sat[k];
            end
        end
    end

    // output register with skid register
    logic          out_v_reg, skid_v_reg;
    logic [DW-1:0] out_d_reg, skid_d_reg;
    logic          out_u_reg, skid_u_reg;
    logic          pipe_word;

    assign en        = !skid_v_reg;
    assign pipe_word = en && dv_v[QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_tready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= pipe_word;
            end
        end else if (pipe_word) begin
            skid_v_reg <= 1'b1;
        end
    end

    // move data alongside the valid bits
    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            if (skid_v_reg) begin
                out_d_reg <= skid_d_reg;
                out_u_reg <= skid_u_reg;
            end else begin
                out_d_reg <= res_data;
                out_u_reg <= dv_deg[QW];
            end
        end else if (pipe_word) begin
            skid_d_reg <= res_data;
            skid_u_reg <= dv_deg[QW];
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_W'(out_d_reg);
    assign m_tuser  = out_u_reg;
endmodule
`default_nettype wire

[hw/rtl/fun_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
`default_nettype none
module fun_sqrt_cell #(
    parameter int PAY_W   = 1,
    parameter int BIT_POS = 62
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      en,
    input  wire                      in_valid,
    input  wire [fun_pkg::SUM_W-1:0] in_rem,
    input  wire [fun_pkg::SUM_W-1:0] in_res,
    input  wire [PAY_W-1:0]          in_pay,
    output logic                     out_valid,
    output logic [fun_pkg::SUM_W-1:0] out_rem,
    output logic [fun_pkg::SUM_W-1:0] out_res,
    output logic [PAY_W-1:0]         out_pay
);
    localparam logic [fun_pkg::SUM_W-1:0] BIT_VAL = fun_pkg::SUM_W'(1) << BIT_POS;

    logic                      valid_reg;
    logic [fun_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [fun_pkg::SUM_W-1:0] res_reg, res_next;
    logic [PAY_W-1:0]          pay_reg;
    logic [fun_pkg::SUM_W-1:0] trial;

    // try one root digit
    always_comb begin
        trial = in_res + BIT_VAL;
        if (in_rem >= trial) begin
            rem_next = in_rem - trial;
            res_next = (in_res >> 1) + BIT_VAL;
        end else begin
            rem_next = in_rem;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // advance data
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_res   = res_reg;
    assign out_pay   = pay_reg;
endmodule
`default_nettype wire

[hw/rtl/fun_div_cell.sv]
// One quotient-bit cell of the three-lane restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module fun_div_cell #(
    parameter int FRAC_BITS = fun_pkg::FRAC_BITS_DEF,
    parameter int BIT_POS   = 0,
    parameter int NW        = fun_pkg::NORM_W + FRAC_BITS + 2,
    parameter int QW        = FRAC_BITS + 2
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        en,
    input  wire                        in_valid,
    input  wire [NW-1:0]               in_rem [3],
    input  wire [QW-1:0]               in_q [3],
    input  wire [fun_pkg::ROOT_W-1:0]  in_r,
    input  wire [2:0]                  in_sign,
    input  wire                        in_deg,
    output logic                       out_valid,
    output logic [NW-1:0]              out_rem [3],
    output logic [QW-1:0]              out_q [3],
    output logic [fun_pkg::ROOT_W-1:0] out_r,
    output logic [2:0]                 out_sign,
    output logic                       out_deg
);
    logic                       valid_reg;
    logic [NW-1:0]              rem_reg [3];
    logic [NW-1:0]              rem_next [3];
    logic [QW-1:0]              q_reg [3];
    logic [QW-1:0]              q_next [3];
    logic [fun_pkg::ROOT_W-1:0] r_reg;
    logic [2:0]                 sign_reg;
    logic                       deg_reg;
    logic [NW-1:0]              dvs;

    // subtract the shifted divisor where it fits
    always_comb begin
        dvs = NW'(in_r) << BIT_POS;
        for (int k = 0; k < 3; k++) begin
            q_next[k] = in_q[k];
            if (in_rem[k] >= dvs) begin
                rem_next[k]        = in_rem[k] - dvs;
                q_next[k][BIT_POS] = 1'b1;
            end else begin
                rem_next[k] = in_rem[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // advance data
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            r_reg    <= in_r;
            sign_reg <= in_sign;
            deg_reg  <= in_deg;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_r     = r_reg;
    assign out_sign  = sign_reg;
    assign out_deg   = deg_reg;
endmodule
`default_nettype wire
